FILE: hdl/htld_pkg.sv
// Shared types and constants of the pre-order Huffman tree loader and decoder.
// Used by every module under hdl; depends on nothing.
`default_nettype none

package htld_pkg;

   localparam int unsigned CMD_W          = 2;
   localparam int unsigned SYM_W          = 8;
   localparam int unsigned REQ_DATA_W     = 16;
   localparam int unsigned RSP_DATA_W     = 8;
   localparam int unsigned RSP_FIFO_DEPTH = 4;
   localparam int unsigned RSP_PTR_W      = 2;
   localparam int unsigned RSP_LVL_W      = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_SHAPE = 2'd1,
      CMD_LEAF  = 2'd2,
      CMD_MSG   = 2'd3
   } cmd_type;

endpackage

`default_nettype wire

FILE: hdl/htld_rsp_fifo.sv
// Result queue of the Huffman decoder: four registered entries in front of the rsp channel.
// Depends on htld_pkg.
`default_nettype none

module htld_rsp_fifo
   import htld_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [RSP_DATA_W-1:0] push_data,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [RSP_LVL_W-1:0]       level
);

   logic [RSP_DATA_W-1:0] q_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_LVL_W-1:0]  level_ff, level_in;
   logic                  pop;

   assign rsp_tvalid = (level_ff != '0);
   assign rsp_tdata  = q_ff[rd_ptr_ff];
   assign level      = level_ff;
   assign pop        = rsp_tvalid & rsp_tready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/huffman_tree_load_and_decode_core.sv
// Top level of the pre-order Huffman tree loader and decoder.
// Depends on htld_pkg and htld_rsp_fifo.
//
// The req channel carries one command per transfer: clear, tree shape bit, leaf
// symbol or message bit. Shape bits build the tree in pre-order (1 internal,
// 0 leaf); leaf symbols follow in pre-order leaf order; message bits then walk
// the tree and each leaf reached yields one transfer on the rsp channel.
// A command may follow in every cycle while req_tready is high. The
// rate is set by the node-table loop: the child read for one message bit gives
// the address of the next read, and the synchronous node memory closes that
// loop each cycle. A result reaches rsp_tvalid through the leaf-table read
// register and then the queue write. Results queue in four registered
// entries; req_tready falls only when the queue and the result in flight
// would fill it, so a stalled receiver halts the input once four results are
// queued or in flight. Reset and the clear command empty the tree, the pending
// stack and the walk; the tables keep their contents and are never swept, so
// the block is ready as soon as reset is released.
`default_nettype none

module huffman_tree_load_and_decode_core
   import htld_pkg::*;
#(
   parameter int unsigned MAX_LEAVES  = 256,
   parameter int unsigned SYMBOL_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [0] bit_value, [8:1] symbol, zero pad
   input  wire logic [CMD_W-1:0]      req_tuser,  // [1:0] command
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata   // [7:0] decoded_symbol
);

   localparam int unsigned IDX_W      = $clog2(MAX_LEAVES);
   localparam int unsigned CNT_W      = IDX_W + 1;
   localparam int unsigned REF_W      = IDX_W + 1;
   localparam int unsigned NODE_DEPTH = MAX_LEAVES - 1;
   localparam int unsigned NA_W       = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
   localparam int unsigned STK_DEPTH  = 1 << NA_W;
   localparam int unsigned SW         = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;

   function automatic logic [NA_W-1:0] clamp_pos(input logic [IDX_W-1:0] idx);
      logic [NA_W-1:0] r;
      r = '0;
      if (CNT_W'(idx) < CNT_W'(NODE_DEPTH)) begin
         r = idx[NA_W-1:0];
      end
      return r;
   endfunction

   logic [REF_W-1:0] node0_mem [NODE_DEPTH];
   logic [REF_W-1:0] node1_mem [NODE_DEPTH];
   logic [SW-1:0]    leaf_mem  [MAX_LEAVES];
   logic [NA_W-1:0]  stk_mem   [STK_DEPTH];

   logic             fill_root_ff, fill_root_in;
   logic             fill_done_ff, fill_done_in;
   logic             fill_side_ff, fill_side_in;
   logic [NA_W-1:0]  fill_node_ff, fill_node_in;
   logic [CNT_W-1:0] int_cnt_ff, int_cnt_in;
   logic [CNT_W-1:0] lf_cnt_ff, lf_cnt_in;
   logic [CNT_W-1:0] lw_cnt_ff, lw_cnt_in;
   logic             root_leaf_ff, root_leaf_in;
   logic [IDX_W-1:0] root_idx_ff, root_idx_in;
   logic [NA_W-1:0]  walk_ff, walk_in;
   logic [CNT_W-1:0] sp_ff, sp_in;
   logic [NA_W-1:0]  tos_ff, tos_in;
   logic             s2_v_ff, s2_v_in;

   logic [REF_W-1:0] node0_rd_ff, node1_rd_ff;
   logic             node0_fwd_ff, node1_fwd_ff;
   logic [REF_W-1:0] node0_fwdd_ff, node1_fwdd_ff;
   logic [NA_W-1:0]  stk_rd_ff;
   logic             stk_fwd_ff;
   logic [NA_W-1:0]  stk_fwdd_ff;
   logic [SW-1:0]    leaf_rd_ff;

   logic             accept;
   cmd_type          cmd;
   logic             bit_v;
   logic [SYM_W-1:0] sym_in;
   logic             place;
   logic [REF_W-1:0] place_ref;
   logic             ovr;
   logic [REF_W-1:0] entry0, entry1, child;
   logic [NA_W-1:0]  below;
   logic [CNT_W-1:0] sp_m1, sp_m2_in;
   logic [NA_W-1:0]  stk_ra;
   logic             stk_we;
   logic [NA_W-1:0]  stk_wa, stk_wd;
   logic             node0_we, node1_we;
   logic [REF_W-1:0] node0_wd, node1_wd;
   logic             leaf_we;
   logic             emit;
   logic [IDX_W-1:0] leaf_ra;
   logic [RSP_LVL_W-1:0] rsp_level;

   assign accept = req_tvalid & req_tready;
   assign cmd    = cmd_type'(req_tuser);
   assign bit_v  = req_tdata[0];
   assign sym_in = req_tdata[SYM_W:1];

   assign req_tready = (RSP_LVL_W'(rsp_level) + RSP_LVL_W'(s2_v_ff))
                       <= RSP_LVL_W'(RSP_FIFO_DEPTH - 1);

   assign ovr    = !fill_root_ff && !fill_done_ff && !fill_side_ff && (walk_ff == fill_node_ff);
   assign entry0 = ovr ? '0 : (node0_fwd_ff ? node0_fwdd_ff : node0_rd_ff);
   assign entry1 = ovr ? '0 : (node1_fwd_ff ? node1_fwdd_ff : node1_rd_ff);
   assign child  = bit_v ? entry1 : entry0;
   assign below  = stk_fwd_ff ? stk_fwdd_ff : stk_rd_ff;
   assign sp_m1  = sp_ff - 1'b1;

   always_comb begin
      fill_root_in = fill_root_ff;
      fill_done_in = fill_done_ff;
      fill_side_in = fill_side_ff;
      fill_node_in = fill_node_ff;
      int_cnt_in   = int_cnt_ff;
      lf_cnt_in    = lf_cnt_ff;
      lw_cnt_in    = lw_cnt_ff;
      root_leaf_in = root_leaf_ff;
      root_idx_in  = root_idx_ff;
      walk_in      = walk_ff;
      sp_in        = sp_ff;
      tos_in       = tos_ff;
      place        = 1'b0;
      place_ref    = '0;
      stk_we       = 1'b0;
      stk_wa       = sp_m1[NA_W-1:0];
      stk_wd       = tos_ff;
      node0_we     = 1'b0;
      node1_we     = 1'b0;
      node0_wd     = '0;
      node1_wd     = '0;
      leaf_we      = 1'b0;
      emit         = 1'b0;
      leaf_ra      = root_idx_ff;

      if (accept) begin
         case (cmd)
            CMD_CLEAR: begin
               fill_root_in = 1'b1;
               fill_done_in = 1'b0;
               fill_side_in = 1'b0;
               fill_node_in = '0;
               int_cnt_in   = '0;
               lf_cnt_in    = '0;
               lw_cnt_in    = '0;
               root_leaf_in = 1'b0;
               root_idx_in  = '0;
               walk_in      = '0;
               sp_in        = '0;
            end
            CMD_SHAPE: begin
               if (!fill_done_ff) begin
                  if (bit_v) begin
                     if (int_cnt_ff < CNT_W'(NODE_DEPTH)) begin
                        place        = 1'b1;
                        place_ref    = {1'b0, int_cnt_ff[IDX_W-1:0]};
                        int_cnt_in   = int_cnt_ff + 1'b1;
                        stk_we       = (sp_ff != '0);
                        tos_in       = int_cnt_ff[NA_W-1:0];
                        sp_in        = sp_ff + 1'b1;
                        fill_root_in = 1'b0;
                        fill_node_in = int_cnt_ff[NA_W-1:0];
                        fill_side_in = 1'b0;
                     end
                  end else if (lf_cnt_ff < CNT_W'(MAX_LEAVES)) begin
                     place        = 1'b1;
                     place_ref    = {1'b1, lf_cnt_ff[IDX_W-1:0]};
                     lf_cnt_in    = lf_cnt_ff + 1'b1;
                     fill_root_in = 1'b0;
                     if (sp_ff != '0) begin
                        sp_in        = sp_m1;
                        fill_node_in = tos_ff;
                        fill_side_in = 1'b1;
                        tos_in       = below;
                     end else begin
                        fill_done_in = 1'b1;
                     end
                  end
               end
            end
            CMD_LEAF: begin
               if (lw_cnt_ff < CNT_W'(MAX_LEAVES)) begin
                  leaf_we   = 1'b1;
                  lw_cnt_in = lw_cnt_ff + 1'b1;
               end
            end
            CMD_MSG: begin
               if (!fill_root_ff) begin
                  if (root_leaf_ff) begin
                     emit    = 1'b1;
                     leaf_ra = root_idx_ff;
                  end else if (child[IDX_W]) begin
                     emit    = 1'b1;
                     leaf_ra = child[IDX_W-1:0];
                     walk_in = clamp_pos(root_idx_ff);
                  end else begin
                     walk_in = clamp_pos(child[IDX_W-1:0]);
                  end
               end
            end
            default: begin
               fill_root_in = fill_root_ff;
            end
         endcase

         if (place) begin
            if (fill_root_ff) begin
               root_leaf_in = place_ref[IDX_W];
               root_idx_in  = place_ref[IDX_W-1:0];
               walk_in      = clamp_pos(place_ref[IDX_W-1:0]);
            end else if (!fill_side_ff) begin
               node0_we = 1'b1;
               node0_wd = place_ref;
               node1_we = 1'b1;
               node1_wd = '0;
            end else begin
               node1_we = 1'b1;
               node1_wd = place_ref;
            end
         end
      end
   end

   assign sp_m2_in = sp_in - CNT_W'(2);
   assign stk_ra   = sp_m2_in[NA_W-1:0];
   assign s2_v_in  = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_root_ff <= 1'b1;
         fill_done_ff <= 1'b0;
         fill_side_ff <= 1'b0;
         fill_node_ff <= '0;
         int_cnt_ff   <= '0;
         lf_cnt_ff    <= '0;
         lw_cnt_ff    <= '0;
         root_leaf_ff <= 1'b0;
         root_idx_ff  <= '0;
         walk_ff      <= '0;
         sp_ff        <= '0;
         s2_v_ff      <= 1'b0;
      end else begin
         fill_root_ff <= fill_root_in;
         fill_done_ff <= fill_done_in;
         fill_side_ff <= fill_side_in;
         fill_node_ff <= fill_node_in;
         int_cnt_ff   <= int_cnt_in;
         lf_cnt_ff    <= lf_cnt_in;
         lw_cnt_ff    <= lw_cnt_in;
         root_leaf_ff <= root_leaf_in;
         root_idx_ff  <= root_idx_in;
         walk_ff      <= walk_in;
         sp_ff        <= sp_in;
         s2_v_ff      <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
   end

   always_ff @(posedge clock) begin
      if (node0_we) begin
         node0_mem[fill_node_ff] <= node0_wd;
      end
      node0_rd_ff   <= node0_mem[walk_in];
      node0_fwd_ff  <= node0_we && (fill_node_ff == walk_in);
      node0_fwdd_ff <= node0_wd;
   end

   always_ff @(posedge clock) begin
      if (node1_we) begin
         node1_mem[fill_node_ff] <= node1_wd;
      end
      node1_rd_ff   <= node1_mem[walk_in];
      node1_fwd_ff  <= node1_we && (fill_node_ff == walk_in);
      node1_fwdd_ff <= node1_wd;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff   <= stk_mem[stk_ra];
      stk_fwd_ff  <= stk_we && (stk_wa == stk_ra);
      stk_fwdd_ff <= stk_wd;
   end

   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[lw_cnt_ff[IDX_W-1:0]] <= sym_in[SW-1:0];
      end
      if (emit) begin
         leaf_rd_ff <= leaf_mem[leaf_ra];
      end
   end

   htld_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (s2_v_ff),
      .push_data  (RSP_DATA_W'(leaf_rd_ff)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .level      (rsp_level)
   );

endmodule

`default_nettype wire

FILE: hdl/htld_checker.sv
// Port-level checks of huffman_tree_load_and_decode_core, attached by bind.
// Depends on htld_pkg and the top level's port list.
`default_nettype none

module htld_checker
   import htld_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [CMD_W-1:0]      req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_rsp_from_msg: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && (req_tuser == CMD_MSG), 2))
      else $error("result without a message bit transfer two cycles earlier");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty result queue");

endmodule

bind huffman_tree_load_and_decode_core htld_checker u_htld_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
